### src/rdi_pkg.sv
// Shared types, widths and helpers for the ray/disk intersection pipeline.
package rdi_pkg;

   localparam int NumW    = 67;   // sum of three 65-bit products
   localparam int DenW    = 66;   // sum of three 64-bit products
   localparam int MagNumW = 65;
   localparam int MagDenW = 64;
   localparam int RemW    = MagNumW + 16;
   localparam int ShW     = 96;
   localparam int QuoW    = 31;
   localparam int DivDepth = QuoW + 1;
   localparam int PointW  = 50;
   localparam int ErrW    = 24;

   typedef enum logic [2:0] {
      CSR_CENTER_X, CSR_CENTER_Y, CSR_CENTER_Z,
      CSR_NORMAL_X, CSR_NORMAL_Y, CSR_NORMAL_Z,
      CSR_RADIUS_SQUARED, CSR_MIN_DISTANCE
   } csr_index_type;

   typedef struct packed {
      logic signed [31:0] dir_z;
      logic signed [31:0] dir_y;
      logic signed [31:0] dir_x;
      logic signed [31:0] origin_z;
      logic signed [31:0] origin_y;
      logic signed [31:0] origin_x;
   } ray_type;

   typedef struct packed {
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic signed [31:0] center_z;
      logic signed [31:0] normal_x;
      logic signed [31:0] normal_y;
      logic signed [31:0] normal_z;
      logic [31:0]        radius_squared;
      logic [15:0]        min_distance;
   } cfg_type;

   typedef struct packed {
      ray_type           ray;
      logic              miss;
      logic              sat;
      logic [RemW-1:0]   rem;
      logic [MagDenW-1:0] den;
      logic [QuoW-1:0]   quo;
   } div_type;

   typedef struct packed {
      logic signed [31:0] hit_z;
      logic signed [31:0] hit_y;
      logic signed [31:0] hit_x;
      logic signed [31:0] hit_distance;
      logic               is_hit;
   } result_type;

   // Clamp a hit coordinate to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [PointW-1:0] x);
      logic signed [31:0] r;
      if (x > 50'sd2147483647)       r = 32'sh7FFFFFFF;
      else if (x < -50'sd2147483648) r = 32'sh80000000;
      else                           r = x[31:0];
      return r;
   endfunction

endpackage

### src/rdi_dot.sv
// Dot-product front end: products, sums, then sign and magnitude of the quotient operands.
module rdi_dot import rdi_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    in_valid,
   output logic    in_ready,
   input  ray_type in_ray,
   output logic    out_valid,
   input  logic    out_ready,
   output div_type out_data
);

   logic v0_ff, v1_ff, v2_ff;
   logic rdy0, rdy1, rdy2;
   ray_type ray0_ff, ray1_ff;
   logic signed [64:0] pn_ff [3];
   logic signed [63:0] pd_ff [3];
   logic signed [64:0] pn_in [3];
   logic signed [63:0] pd_in [3];
   logic signed [NumW-1:0] num_ff, num_in;
   logic signed [DenW-1:0] den_ff, den_in;
   div_type out_ff, out_in;
   logic signed [31:0] c_ax [3], n_ax [3], o_ax [3], d_ax [3];

   assign rdy2 = !v2_ff || out_ready;
   assign rdy1 = !v1_ff || rdy2;
   assign rdy0 = !v0_ff || rdy1;
   assign in_ready = rdy0;
   assign out_valid = v2_ff;
   assign out_data = out_ff;

   assign c_ax = '{cfg.center_x, cfg.center_y, cfg.center_z};
   assign n_ax = '{cfg.normal_x, cfg.normal_y, cfg.normal_z};
   assign o_ax = '{in_ray.origin_x, in_ray.origin_y, in_ray.origin_z};
   assign d_ax = '{in_ray.dir_x, in_ray.dir_y, in_ray.dir_z};

   // Form the six per-axis products
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pn_in[i] = (33'(c_ax[i]) - 33'(o_ax[i])) * n_ax[i];
         pd_in[i] = d_ax[i] * n_ax[i];
      end
   end

   // Add up numerator and denominator
   always_comb begin
      num_in = NumW'(pn_ff[0]) + NumW'(pn_ff[1]) + NumW'(pn_ff[2]);
      den_in = DenW'(pd_ff[0]) + DenW'(pd_ff[1]) + DenW'(pd_ff[2]);
   end

   // Drop zero or opposite-sign cases, take magnitudes, scale numerator to Q16.16
   always_comb begin
      logic signed [NumW-1:0] nm;
      logic signed [DenW-1:0] dm;
      nm = num_ff[NumW-1] ? -num_ff : num_ff;
      dm = den_ff[DenW-1] ? -den_ff : den_ff;
      out_in.ray  = ray1_ff;
      out_in.miss = (den_ff == '0) || (num_ff == '0) || (num_ff[NumW-1] != den_ff[DenW-1]);
      out_in.sat  = 1'b0;
      out_in.rem  = {nm[MagNumW-1:0], 16'b0};
      out_in.den  = dm[MagDenW-1:0];
      out_in.quo  = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (rdy0) v0_ff <= in_valid;
         if (rdy1) v1_ff <= v0_ff;
         if (rdy2) v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy0) begin
         ray0_ff <= in_ray;
         pn_ff   <= pn_in;
         pd_ff   <= pd_in;
      end
      if (rdy1) begin
         ray1_ff <= ray0_ff;
         num_ff  <= num_in;
         den_ff  <= den_in;
      end
      if (rdy2) out_ff <= out_in;
   end

endmodule

### src/rdi_div.sv
// Pipelined restoring divider: one overflow check then one quotient bit per stage.
module rdi_div import rdi_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  div_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output div_type out_data
);

   logic    v_ff  [DivDepth];
   div_type st_ff [DivDepth];
   div_type st_in [DivDepth];
   logic    rdy   [DivDepth+1];

   assign rdy[DivDepth] = out_ready;
   assign in_ready  = rdy[0];
   assign out_valid = v_ff[DivDepth-1];
   assign out_data  = st_ff[DivDepth-1];

   for (genvar s = 0; s < DivDepth; s++) begin : g_stage
      localparam int K = QuoW - s;
      div_type src;
      logic    src_v;
      logic [ShW-1:0] dsh;
      logic    ge;

      if (s == 0) begin : g_first
         assign src   = in_data;
         assign src_v = in_valid;
      end else begin : g_next
         assign src   = st_ff[s-1];
         assign src_v = v_ff[s-1];
      end

      assign dsh = ShW'(src.den) << K;
      assign ge  = ShW'(src.rem) >= dsh;
      assign rdy[s] = !v_ff[s] || rdy[s+1];

      // Check overflow first, then subtract the shifted divisor where it fits
      always_comb begin
         st_in[s] = src;
         if (s == 0) begin
            st_in[s].sat = ge;
         end else if (!src.sat && ge) begin
            st_in[s].rem = src.rem - dsh[RemW-1:0];
            st_in[s].quo = src.quo | (QuoW'(1) << K);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) v_ff[s] <= 1'b0;
         else if (rdy[s]) v_ff[s] <= src_v;
      end

      always_ff @(posedge clock) begin
         if (rdy[s]) st_ff[s] <= st_in[s];
      end
   end

endmodule

### src/rdi_hit.sv
// Hit point back end: t times direction, offset from centre, squares, radius test.
module rdi_hit import rdi_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       in_valid,
   output logic       in_ready,
   input  div_type    in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   logic v0_ff, v1_ff, v2_ff, v3_ff;
   logic rdy0, rdy1, rdy2, rdy3;

   // stage 0
   logic [31:0] t0_ff, t_in;
   logic        miss0_ff, miss_in;
   ray_type     ray0_ff;
   logic signed [64:0] tp_ff [3], tp_in [3];
   // stage 1
   logic [31:0] t1_ff;
   logic        miss1_ff, big_ff, big_in;
   logic signed [PointW-1:0] p1_ff [3], p_in [3];
   logic [ErrW-1:0] ee_ff [3], ee_in [3];
   // stage 2
   logic [31:0] t2_ff;
   logic        miss2_ff;
   logic signed [PointW-1:0] p2_ff [3];
   logic [2*ErrW-1:0] sq_ff [3], sq_in [3];
   // stage 3
   result_type  res_ff, res_in;

   logic signed [31:0] c_ax [3], o_ax [3], d_ax [3];

   assign rdy3 = !v3_ff || out_ready;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign rdy0 = !v0_ff || rdy1;
   assign in_ready  = rdy0;
   assign out_valid = v3_ff;
   assign out_data  = res_ff;

   assign c_ax = '{cfg.center_x, cfg.center_y, cfg.center_z};
   assign o_ax = '{ray0_ff.origin_x, ray0_ff.origin_y, ray0_ff.origin_z};
   assign d_ax = '{in_data.ray.dir_x, in_data.ray.dir_y, in_data.ray.dir_z};

   // Saturate t, reject it at or below the minimum distance, scale direction
   always_comb begin
      t_in = in_data.sat ? 32'h7FFFFFFF : {1'b0, in_data.quo};
      miss_in = in_data.miss || (!in_data.sat && (t_in <= 32'(cfg.min_distance)));
      for (int i = 0; i < 3; i++) begin
         tp_in[i] = $signed({1'b0, t_in}) * d_ax[i];
      end
   end

   // Hit point and its offset from the centre; large offsets miss outright
   always_comb begin
      logic signed [PointW:0] e;
      logic [PointW:0] m;
      big_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         p_in[i] = PointW'(o_ax[i]) + PointW'($signed(tp_ff[i][64:16]));
         e = (PointW+1)'(c_ax[i]) - (PointW+1)'(p_in[i]);
         m = e[PointW] ? -e : e;
         big_in = big_in || (m[PointW:ErrW] != '0);
         ee_in[i] = m[ErrW-1:0];
      end
   end

   // Square each offset
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = (2*ErrW)'(ee_ff[i]) * (2*ErrW)'(ee_ff[i]);
      end
   end

   // Compare distance with the radius and build the result
   always_comb begin
      logic [2*ErrW+1:0] dsum;
      logic [47:0] lim;
      logic hit;
      dsum = (2*ErrW+2)'(sq_ff[0]) + (2*ErrW+2)'(sq_ff[1]) + (2*ErrW+2)'(sq_ff[2]);
      lim  = {cfg.radius_squared, 16'b0};
      hit  = !miss2_ff && (dsum < (2*ErrW+2)'(lim));
      res_in = '0;
      if (hit) begin
         res_in.is_hit       = 1'b1;
         res_in.hit_distance = t2_ff;
         res_in.hit_x        = sat32(p2_ff[0]);
         res_in.hit_y        = sat32(p2_ff[1]);
         res_in.hit_z        = sat32(p2_ff[2]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy0) v0_ff <= in_valid;
         if (rdy1) v1_ff <= v0_ff;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy0) begin
         t0_ff    <= t_in;
         miss0_ff <= miss_in;
         ray0_ff  <= in_data.ray;
         tp_ff    <= tp_in;
      end
      if (rdy1) begin
         t1_ff    <= t0_ff;
         miss1_ff <= miss0_ff;
         big_ff   <= big_in;
         p1_ff    <= p_in;
         ee_ff    <= ee_in;
      end
      if (rdy2) begin
         t2_ff    <= t1_ff;
         miss2_ff <= miss1_ff || big_ff;
         p2_ff    <= p1_ff;
         sq_ff    <= sq_in;
      end
      if (rdy3) res_ff <= res_in;
   end

endmodule

### src/ray_disk_intersect_top.sv
// Ray/disk intersection tester: register file, dot products, divider and hit test.
//
// Requests arrive on req_ (origin x,y,z then direction x,y,z, Q16.16, in
// req_tdata) and one result leaves on rsp_ for each request, in order.
// rsp_tuser carries the hit flag; rsp_tdata carries t and the hit point,
// all zero on a miss. The disk is set through csr_: index 0..7 selects
// centre x,y,z, normal x,y,z, squared radius and minimum distance; write
// only while no request is in flight.
// The pipeline has 3 dot-product stages, 32 divider stages (overflow
// check plus one quotient bit per stage) and 4 hit-test stages.
// Throughput is one request per cycle while rsp_tready is high; every stage
// holds its own valid bit. When rsp_tready is low the results back up stage
// by stage; empty stages still take requests, and req_tready falls only once
// the pipe is full. Reset clears all valid bits and returns the disk registers
// to a unit disk at the origin facing +z with minimum distance one LSB.
module ray_disk_intersect_top import rdi_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [191:0] req_tdata,  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,  // hit_distance, hit_x, hit_y, hit_z
   output logic         rsp_tuser,  // is_hit
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_data
);

   cfg_type    cfg_ff;
   ray_type    req_ray;
   logic       dot_valid, dot_ready, div_valid, div_ready;
   div_type    dot_data, div_data;
   result_type res;

   assign csr_ready = 1'b1;
   assign req_ray   = req_tdata;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{center_x: '0, center_y: '0, center_z: '0,
                     normal_x: '0, normal_y: '0, normal_z: 32'sd65536,
                     radius_squared: 32'd65536, min_distance: 16'd1};
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_CENTER_X:       cfg_ff.center_x       <= csr_data;
            CSR_CENTER_Y:       cfg_ff.center_y       <= csr_data;
            CSR_CENTER_Z:       cfg_ff.center_z       <= csr_data;
            CSR_NORMAL_X:       cfg_ff.normal_x       <= csr_data;
            CSR_NORMAL_Y:       cfg_ff.normal_y       <= csr_data;
            CSR_NORMAL_Z:       cfg_ff.normal_z       <= csr_data;
            CSR_RADIUS_SQUARED: cfg_ff.radius_squared <= csr_data;
            CSR_MIN_DISTANCE:   cfg_ff.min_distance   <= csr_data[15:0];
            default:            ;
         endcase
      end
   end

   rdi_dot u_dot (
      .clock, .reset, .cfg(cfg_ff),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_ray(req_ray),
      .out_valid(dot_valid), .out_ready(dot_ready), .out_data(dot_data)
   );

   rdi_div u_div (
      .clock, .reset,
      .in_valid(dot_valid), .in_ready(dot_ready), .in_data(dot_data),
      .out_valid(div_valid), .out_ready(div_ready), .out_data(div_data)
   );

   rdi_hit u_hit (
      .clock, .reset, .cfg(cfg_ff),
      .in_valid(div_valid), .in_ready(div_ready), .in_data(div_data),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_data(res)
   );

   assign rsp_tdata = {res.hit_z, res.hit_y, res.hit_x, res.hit_distance};
   assign rsp_tuser = res.is_hit;

`ifndef SYNTHESIS
   // A miss reports all-zero data
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("miss with non-zero data");

   // A hit has a positive distance
   a_hit_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> !rsp_tdata[31] && rsp_tdata[31:0] != '0)
      else $error("hit with non-positive distance");

   // Nothing leaves straight after reset
   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");
`endif

endmodule
